### sv/dsf_pkg.sv
`timescale 1ns / 1ps

package dsf_pkg;

	// Fixed field widths of the request and response items
	localparam int POS_W    = 3;
	localparam int DIGIT_W  = 4;
	localparam int COL_W    = 5;
	localparam int STEP_W   = 3;
	localparam int ROWIDX_W = 3;
	localparam int PIX_W    = 32;

	// Default geometry
	localparam int ROWS_DEF      = 8;
	localparam int COLUMNS_DEF   = 32;
	localparam int POSITIONS_DEF = 6;

	// Font geometry and the mark for a position that shows nothing yet
	localparam int GLYPH_ROWS  = 8;
	localparam int GLYPH_COUNT = 10;
	localparam logic [DIGIT_W-1:0] NOTHING_SHOWN = 4'hf;

	typedef struct packed {
		logic [POS_W-1:0]   position;
		logic [DIGIT_W-1:0] digit_value;
		logic [COL_W-1:0]   left_column;
	} req_t;

	typedef struct packed {
		logic [STEP_W-1:0]   step_index;
		logic [ROWIDX_W-1:0] row_index;
		logic [PIX_W-1:0]    row_pixels;
		logic                last;
	} rsp_t;

	// Operation applied to every cell of the row chain in the same cycle
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_CLEAR,
		CELL_SLIDE,
		CELL_ROTATE
	} cell_op_t;

	// 4x8 font, row 0 is the top of the glyph, MSB is the left column
	localparam logic [3:0] FONT [GLYPH_COUNT][GLYPH_ROWS] = '{
		'{4'h6, 4'h9, 4'h9, 4'h9, 4'h9, 4'h9, 4'h9, 4'h6},
		'{4'h2, 4'h6, 4'hA, 4'h2, 4'h2, 4'h2, 4'h2, 4'h7},
		'{4'hE, 4'h1, 4'h1, 4'h1, 4'h2, 4'h4, 4'h8, 4'hF},
		'{4'hE, 4'h1, 4'h1, 4'h6, 4'h1, 4'h1, 4'h9, 4'h6},
		'{4'h8, 4'h9, 4'h9, 4'h9, 4'hF, 4'h1, 4'h1, 4'h1},
		'{4'hF, 4'h8, 4'h8, 4'hE, 4'h1, 4'h1, 4'h9, 4'h6},
		'{4'h7, 4'h8, 4'h8, 4'hE, 4'h9, 4'h9, 4'h9, 4'h6},
		'{4'hF, 4'h9, 4'h1, 4'h2, 4'h4, 4'h4, 4'h4, 4'h4},
		'{4'h6, 4'h9, 4'h9, 4'h6, 4'h9, 4'h9, 4'h9, 4'h6},
		'{4'h6, 4'h9, 4'h9, 4'h9, 4'h7, 4'h1, 4'h1, 4'hE}
	};

	// Glyph row lookup; digits above nine and rows past the font are blank
	function automatic logic [3:0] font_row(input logic [DIGIT_W-1:0] digit,
			input logic [3:0] row);
		logic [3:0] r;
		r = 4'h0;
		if ((int'(digit) < GLYPH_COUNT) && (int'(row) < GLYPH_ROWS)) begin
			r = FONT[digit][row[2:0]];
		end
		return r;
	endfunction

endpackage

### sv/dsf_cell.sv
`timescale 1ns / 1ps

module dsf_cell #(
	parameter int COLUMNS = dsf_pkg::COLUMNS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dsf_pkg::cell_op_t    op,
	input  logic [COLUMNS-1:0]   mask,
	input  logic [COLUMNS-1:0]   from_above,
	input  logic [COLUMNS-1:0]   from_below,
	output logic [COLUMNS-1:0]   row
);

	logic [COLUMNS-1:0] row_q;

	// One display row: hold, clear the slot, slide the slot down, or rotate up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else begin
			case (op)
				dsf_pkg::CELL_CLEAR:  row_q <= row_q & ~mask;
				dsf_pkg::CELL_SLIDE:  row_q <= (row_q & ~mask) | (from_above & mask);
				dsf_pkg::CELL_ROTATE: row_q <= from_below;
				default:              row_q <= row_q;
			endcase
		end
	end

	assign row = row_q;

endmodule

### sv/dsf_row_chain.sv
`timescale 1ns / 1ps

module dsf_row_chain #(
	parameter int ROWS    = dsf_pkg::ROWS_DEF,
	parameter int COLUMNS = dsf_pkg::COLUMNS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dsf_pkg::cell_op_t  op,
	input  logic [COLUMNS-1:0] mask,
	input  logic [COLUMNS-1:0] glyph,
	output logic [COLUMNS-1:0] top_row
);

	logic [COLUMNS-1:0] rows [ROWS];

	// Cell 0 is the top row; the glyph enters there on a slide, and on a
	// rotate the top row wraps around to the bottom cell.
	for (genvar r = 0; r < ROWS; r++) begin : g_cell
		logic [COLUMNS-1:0] above;
		logic [COLUMNS-1:0] below;

		if (r == 0) begin : g_top
			assign above = glyph;
		end else begin : g_mid
			assign above = rows[r-1];
		end

		if (r == ROWS - 1) begin : g_bot
			assign below = rows[0];
		end else begin : g_up
			assign below = rows[r+1];
		end

		dsf_cell #(
			.COLUMNS(COLUMNS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.op        (op),
			.mask      (mask),
			.from_above(above),
			.from_below(below),
			.row       (rows[r])
		);
	end

	assign top_row = rows[0];

endmodule

### sv/digit_slide_in_frame_generator_unit.sv
`timescale 1ns / 1ps
// Sequence: a taken changed digit clears its slot, then for each glyph row slides it in once
// and emits the ROWS rows of the frame through the row chain; the first row leaves the output
// register after the clear and the first slide, and the unit is not ready until the last row.
// An unchanged or out-of-range request is taken and dropped. Output stalls stretch the rows.
// Reset: bitmap cleared to blank, every position marked as showing nothing.
module digit_slide_in_frame_generator_unit #(
	parameter int ROWS      = dsf_pkg::ROWS_DEF,
	parameter int COLUMNS   = dsf_pkg::COLUMNS_DEF,
	parameter int POSITIONS = dsf_pkg::POSITIONS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  dsf_pkg::req_t req_data,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output dsf_pkg::rsp_t rsp_data
);

	localparam int SW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int PW = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_SLIDE,
		ST_EMIT
	} state_t;

	state_t                          state_q;
	logic [dsf_pkg::DIGIT_W-1:0]     shown_q [POSITIONS];
	logic [dsf_pkg::DIGIT_W-1:0]     digit_q;
	logic [dsf_pkg::COL_W-1:0]       col_q;
	logic [COLUMNS-1:0]              mask_q;
	logic [SW-1:0]                   step_q;
	logic [SW-1:0]                   row_q;
	logic                            rsp_valid_q;
	dsf_pkg::rsp_t                   rsp_q;

	logic                            req_take;
	logic                            pos_ok;
	logic [PW-1:0]                   pos_idx;
	logic                            changed;
	logic                            out_free;
	logic [3:0]                      glyph_idx;
	logic [COLUMNS-1:0]              glyph_row;
	logic [COLUMNS-1:0]              top_row;
	dsf_pkg::cell_op_t               cell_op;

	// Put a nibble so that its MSB lands on column col; columns past the edge drop
	function automatic logic [COLUMNS-1:0] place_nibble(input logic [3:0] nib,
			input logic [dsf_pkg::COL_W-1:0] col);
		logic [COLUMNS+3:0] ext;
		ext = {nib, {COLUMNS{1'b0}}} >> (6'(col) + 6'd4);
		return ext[COLUMNS-1:0];
	endfunction

	assign req_ready = (state_q == ST_IDLE);
	assign req_take  = req_valid && req_ready;
	assign pos_ok    = int'(req_data.position) < POSITIONS;
	assign pos_idx   = PW'(req_data.position);
	assign changed   = pos_ok && (shown_q[pos_idx] != req_data.digit_value);
	assign out_free  = !rsp_valid_q || rsp_ready;

	// Glyph rows enter bottom row first
	assign glyph_idx = 4'(ROWS - 1) - 4'(step_q);
	assign glyph_row = place_nibble(dsf_pkg::font_row(digit_q, glyph_idx), col_q);

	// Chain operation for this cycle
	always_comb begin
		case (state_q)
			ST_CLEAR: cell_op = dsf_pkg::CELL_CLEAR;
			ST_SLIDE: cell_op = dsf_pkg::CELL_SLIDE;
			ST_EMIT:  cell_op = out_free ? dsf_pkg::CELL_ROTATE : dsf_pkg::CELL_HOLD;
			default:  cell_op = dsf_pkg::CELL_HOLD;
		endcase
	end

	dsf_row_chain #(
		.ROWS   (ROWS),
		.COLUMNS(COLUMNS)
	) u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (cell_op),
		.mask   (mask_q),
		.glyph  (glyph_row),
		.top_row(top_row)
	);

	// Sequencer and remembered digits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			row_q   <= '0;
			for (int i = 0; i < POSITIONS; i++) begin
				shown_q[i] <= dsf_pkg::NOTHING_SHOWN;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_take && changed) begin
						shown_q[pos_idx] <= req_data.digit_value;
						state_q          <= ST_CLEAR;
					end
				end
				ST_CLEAR: begin
					step_q  <= '0;
					state_q <= ST_SLIDE;
				end
				ST_SLIDE: begin
					row_q   <= '0;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						if (int'(row_q) == ROWS - 1) begin
							if (int'(step_q) == ROWS - 1) begin
								state_q <= ST_IDLE;
							end else begin
								step_q  <= step_q + SW'(1);
								state_q <= ST_SLIDE;
							end
						end else begin
							row_q <= row_q + SW'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Latched request fields for the slide
	always_ff @(posedge clk) begin
		if (req_take) begin
			digit_q <= req_data.digit_value;
			col_q   <= req_data.left_column;
			mask_q  <= place_nibble(4'hf, req_data.left_column);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			rsp_q.step_index <= dsf_pkg::STEP_W'(step_q);
			rsp_q.row_index  <= dsf_pkg::ROWIDX_W'(row_q);
			rsp_q.row_pixels <= dsf_pkg::PIX_W'(top_row);
			rsp_q.last       <= (int'(step_q) == ROWS - 1) && (int'(row_q) == ROWS - 1);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam int CLK_HALF       = 4;
	localparam int N_ROWS         = dsf_pkg::ROWS_DEF;
	localparam int N_POSITIONS    = dsf_pkg::POSITIONS_DEF;
	localparam int RANDOM_CHANGES = 120;
	localparam int HOLDOFF_CYCLES = 400;
	localparam int DRAIN_CYCLES   = 20;

	// Receiver stall patterns
	typedef enum int {
		RX_ALWAYS,
		RX_COIN,
		RX_TWO_OF_THREE,
		RX_SPARSE
	} rx_mode_t;

	// 4x8 digit font, row 0 is the top of the glyph, MSB is the left column
	localparam logic [3:0] GLYPHS [10][8] = '{
		'{4'h6, 4'h9, 4'h9, 4'h9, 4'h9, 4'h9, 4'h9, 4'h6},
		'{4'h2, 4'h6, 4'hA, 4'h2, 4'h2, 4'h2, 4'h2, 4'h7},
		'{4'hE, 4'h1, 4'h1, 4'h1, 4'h2, 4'h4, 4'h8, 4'hF},
		'{4'hE, 4'h1, 4'h1, 4'h6, 4'h1, 4'h1, 4'h9, 4'h6},
		'{4'h8, 4'h9, 4'h9, 4'h9, 4'hF, 4'h1, 4'h1, 4'h1},
		'{4'hF, 4'h8, 4'h8, 4'hE, 4'h1, 4'h1, 4'h9, 4'h6},
		'{4'h7, 4'h8, 4'h8, 4'hE, 4'h9, 4'h9, 4'h9, 4'h6},
		'{4'hF, 4'h9, 4'h1, 4'h2, 4'h4, 4'h4, 4'h4, 4'h4},
		'{4'h6, 4'h9, 4'h9, 4'h6, 4'h9, 4'h9, 4'h9, 4'h6},
		'{4'h6, 4'h9, 4'h9, 4'h9, 4'h7, 4'h1, 4'h1, 4'hE}
	};

	logic           clk;
	logic           arst_n    = 1'b0;
	logic           req_valid = 1'b0;
	logic           req_ready;
	dsf_pkg::req_t  req_data  = '0;
	logic           rsp_valid;
	logic           rsp_ready = 1'b0;
	dsf_pkg::rsp_t  rsp_data;

	// Predicted display state
	logic [dsf_pkg::PIX_W-1:0]   bitmap [N_ROWS];
	logic [dsf_pkg::DIGIT_W-1:0] shown [N_POSITIONS];
	dsf_pkg::rsp_t               frames_due [$];

	int n_errors     = 0;
	int burst_left   = 0;
	bit holdoff_req  = 1'b0;

	digit_slide_in_frame_generator_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Slot nibble placed with its high bit on column col; bits past the edge drop off
	function automatic logic [dsf_pkg::PIX_W-1:0] nibble_at(input logic [3:0] nib,
			input logic [dsf_pkg::COL_W-1:0] col);
		logic [dsf_pkg::PIX_W+3:0] wide;
		wide = {nib, {dsf_pkg::PIX_W{1'b0}}} >> col;
		return wide[dsf_pkg::PIX_W+3:4];
	endfunction

	function automatic logic [3:0] glyph_nibble(input logic [dsf_pkg::DIGIT_W-1:0] digit,
			input int row);
		if (digit > 4'd9 || row >= 8)
			return 4'h0;
		return GLYPHS[digit][row];
	endfunction

	// Slide-in of a changed digit: clear the slot, then eight shift steps, each
	// followed by the whole frame top row first
	function automatic void predict_slide(input dsf_pkg::req_t r);
		logic [dsf_pkg::PIX_W-1:0] slot;
		dsf_pkg::rsp_t             row_out;
		if (r.position >= N_POSITIONS)
			return;
		if (shown[r.position] == r.digit_value)
			return;
		shown[r.position] = r.digit_value;
		slot = nibble_at(4'hf, r.left_column);
		for (int k = 0; k < N_ROWS; k++)
			bitmap[k] &= ~slot;
		for (int s = 0; s < N_ROWS; s++) begin
			for (int k = N_ROWS - 1; k >= 1; k--)
				bitmap[k] = (bitmap[k] & ~slot) | (bitmap[k-1] & slot);
			bitmap[0] = (bitmap[0] & ~slot)
				| nibble_at(glyph_nibble(r.digit_value, N_ROWS - 1 - s), r.left_column);
			for (int k = 0; k < N_ROWS; k++) begin
				row_out.step_index = s[dsf_pkg::STEP_W-1:0];
				row_out.row_index  = k[dsf_pkg::ROWIDX_W-1:0];
				row_out.row_pixels = bitmap[k];
				row_out.last       = (s == N_ROWS - 1) && (k == N_ROWS - 1);
				frames_due.push_back(row_out);
			end
		end
	endfunction

	// Offer one request in bursts with random gaps; returns once it is taken
	task automatic send_req(input logic [dsf_pkg::POS_W-1:0] pos,
			input logic [dsf_pkg::DIGIT_W-1:0] digit,
			input logic [dsf_pkg::COL_W-1:0] col);
		dsf_pkg::req_t r;
		r.position    = pos;
		r.digit_value = digit;
		r.left_column = col;
		@(negedge clk);
		if (burst_left == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40)
				: $urandom_range(1, 6);
		end
		burst_left--;
		req_valid <= 1'b1;
		req_data  <= r;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		predict_slide(r);
	endtask

	task automatic stop_sending();
		@(negedge clk);
		req_valid <= 1'b0;
		burst_left = 0;
	endtask

	// Field extremes and the special cases
	task automatic test_directed();
		send_req(3'd0, 4'd0, 5'd0);
		send_req(3'd5, 4'd9, 5'd28);
		send_req(3'd0, 4'd0, 5'd0);      // same digit again: silent
		send_req(3'd1, 4'd15, 5'd4);     // matches the nothing-shown mark: silent
		send_req(3'd6, 4'd3, 5'd8);      // position out of range
		send_req(3'd7, 4'd8, 5'd12);
		send_req(3'd1, 4'd12, 5'd4);     // blank glyph still clears the slot
		send_req(3'd2, 4'd1, 5'd29);     // slot partly past the right edge
		send_req(3'd3, 4'd2, 5'd30);
		send_req(3'd4, 4'd3, 5'd31);
		send_req(3'd2, 4'd4, 5'd8);
		send_req(3'd3, 4'd5, 5'd12);
		send_req(3'd4, 4'd6, 5'd16);
		send_req(3'd0, 4'd7, 5'd20);
		send_req(3'd5, 4'd8, 5'd24);
		send_req(3'd0, 4'd10, 5'd0);
		send_req(3'd2, 4'd11, 5'd8);
		send_req(3'd3, 4'd13, 5'd2);     // overlaps a neighbor slot
		send_req(3'd4, 4'd14, 5'd16);
		send_req(3'd5, 4'd15, 5'd28);    // written position, so fifteen now differs
		send_req(3'd1, 4'd9, 5'd21);
		stop_sending();
	endtask

	// Receiver holds off for a long stretch while requests keep coming
	task automatic test_output_holdoff();
		holdoff_req = 1'b1;
		for (int i = 0; i < 8; i++)
			send_req(3'(i % N_POSITIONS), 4'($urandom_range(0, 9)), 5'(4 * (i % 8)));
		stop_sending();
	endtask

	// Mostly changed digits with random content, some silent and ignored requests
	task automatic test_random_digits();
		int                          changes;
		int                          pick;
		logic [dsf_pkg::POS_W-1:0]   pos;
		logic [dsf_pkg::DIGIT_W-1:0] digit;
		logic [dsf_pkg::COL_W-1:0]   col;
		changes = 0;
		while (changes < RANDOM_CHANGES) begin
			pick  = $urandom_range(0, 99);
			pos   = 3'($urandom_range(0, N_POSITIONS - 1));
			digit = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(10, 15))
				: 4'($urandom_range(0, 9));
			col   = ($urandom_range(0, 6) == 0) ? 5'($urandom_range(29, 31))
				: 5'($urandom_range(0, 28));
			if (pick < 5)
				pos = 3'($urandom_range(N_POSITIONS, 7));
			else if (pick < 15)
				digit = shown[pos];
			else if (digit == shown[pos])
				digit = digit + 4'd1;
			if (pos < N_POSITIONS && digit != shown[pos])
				changes++;
			send_req(pos, digit, col);
		end
		stop_sending();
	endtask

	// Receiver readiness: patterns of random length plus the long hold-off
	initial begin
		rx_mode_t mode;
		int       span;
		int       cyc;
		mode = RX_ALWAYS;
		span = 0;
		cyc  = 0;
		forever begin
			@(negedge clk);
			cyc++;
			if (holdoff_req) begin
				rsp_ready <= 1'b0;
				repeat (HOLDOFF_CYCLES) @(negedge clk);
				holdoff_req = 1'b0;
			end else begin
				if (span == 0) begin
					mode = rx_mode_t'($urandom_range(0, 3));
					span = $urandom_range(20, 150);
				end
				span--;
				case (mode)
					RX_ALWAYS:       rsp_ready <= 1'b1;
					RX_COIN:         rsp_ready <= 1'($urandom_range(0, 1));
					RX_TWO_OF_THREE: rsp_ready <= (cyc % 3) != 0;
					default:         rsp_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// Compare each taken row with the oldest predicted one
	always @(posedge clk) begin : row_check
		dsf_pkg::rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (frames_due.size() == 0) begin
				n_errors++;
				$display("%0t: unexpected row: expected none, actual %0d/%0d %h %b",
					$time, rsp_data.step_index, rsp_data.row_index, rsp_data.row_pixels,
					rsp_data.last);
			end else begin
				want = frames_due.pop_front();
				if (rsp_data.step_index !== want.step_index
						|| rsp_data.row_index !== want.row_index
						|| rsp_data.row_pixels !== want.row_pixels
						|| rsp_data.last !== want.last) begin
					n_errors++;
					$display("%0t: mismatch: expected %0d/%0d %h %b, actual %0d/%0d %h %b",
						$time, want.step_index, want.row_index, want.row_pixels, want.last,
						rsp_data.step_index, rsp_data.row_index, rsp_data.row_pixels,
						rsp_data.last);
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		for (int k = 0; k < N_ROWS; k++)
			bitmap[k] = '0;
		for (int p = 0; p < N_POSITIONS; p++)
			shown[p] = dsf_pkg::NOTHING_SHOWN;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_output_holdoff();
		test_random_digits();

		wait (frames_due.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
